// ===== rtl/chd_pkg.sv =====
// ----------------------------------------------------------------------------
// chd_pkg: shared types and codes of the canonical Huffman decoder
// Item and result layouts, opcodes, status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package chd_pkg;

  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;
  localparam int CNT_W  = 9;
  localparam int STAT_W = 2;

  // opcodes
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_BUILD = 2'd2;
  localparam logic [1:0] OP_BIT   = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_OVERRUN = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_BAD     = 2'd2;

  // shortest length while no code is known
  localparam logic [LEN_W-1:0] LEN_NONE = 6'd63;

  typedef struct packed {
    logic [1:0]       opcode;
    logic [SYM_W-1:0] symbol_in;
    logic [LEN_W-1:0] code_length;
    logic             bit_value;
  } item_t;

  typedef struct packed {
    logic [SYM_W-1:0]  symbol_out;
    logic [STAT_W-1:0] status;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LOOK,
    S_FETCH,
    S_PUSH
  } state_t;

  typedef struct packed {
    logic accept;  // item transfer this cycle
    logic walk;    // one length step of the build walk
    logic look;    // compare codeword against limit
    logic fetch;   // read ranked symbol
    logic push;    // move pending result to output register
  } cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       load_bad;
    logic       has_symbols;
    logic       table_ready;
    logic       walk_last;
    logic       match;
    logic       overrun;
    logic       out_free;
  } sts_t;

endpackage

// ===== rtl/chd_chan_if.sv =====
// ----------------------------------------------------------------------------
// chd_chan_if: valid/ready channel
// Carries one payload per transfer; transfer when valid and ready are high.
// ----------------------------------------------------------------------------
interface chd_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/chd_ctrl.sv =====
// ----------------------------------------------------------------------------
// chd_ctrl: sequencer of the canonical Huffman decoder
// Steps each item through the states that it needs: walk, lookup, fetch, result push.
// ----------------------------------------------------------------------------
module chd_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  chd_pkg::sts_t  sts,
  output chd_pkg::cmd_t  cmd
);

  chd_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= chd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      chd_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (sts.opcode)
            chd_pkg::OP_CLEAR: state_next = chd_pkg::S_IDLE;
            chd_pkg::OP_LOAD: begin
              state_next = sts.load_bad ? chd_pkg::S_PUSH : chd_pkg::S_IDLE;
            end
            chd_pkg::OP_BUILD: begin
              state_next = sts.has_symbols ? chd_pkg::S_WALK : chd_pkg::S_IDLE;
            end
            chd_pkg::OP_BIT: begin
              state_next = sts.table_ready ? chd_pkg::S_LOOK : chd_pkg::S_PUSH;
            end
          endcase
        end
      end
      chd_pkg::S_WALK: begin
        if (sts.walk_last) state_next = chd_pkg::S_IDLE;
      end
      chd_pkg::S_LOOK: begin
        if (sts.match)        state_next = chd_pkg::S_FETCH;
        else if (sts.overrun) state_next = chd_pkg::S_PUSH;
        else                  state_next = chd_pkg::S_IDLE;
      end
      chd_pkg::S_FETCH: state_next = chd_pkg::S_PUSH;
      chd_pkg::S_PUSH: begin
        if (sts.out_free) state_next = chd_pkg::S_IDLE;
      end
      default: state_next = chd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      chd_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      chd_pkg::S_WALK:  cmd.walk  = 1'b1;
      chd_pkg::S_LOOK:  cmd.look  = 1'b1;
      chd_pkg::S_FETCH: cmd.fetch = 1'b1;
      chd_pkg::S_PUSH:  cmd.push  = sts.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/chd_datapath.sv =====
// ----------------------------------------------------------------------------
// chd_datapath: tables, codeword and result registers
// Symbol store, per-length counts, limits and rank ends, decode compare,
// output register.
// ----------------------------------------------------------------------------
module chd_datapath #(
  parameter int ALPHABET = 256,
  parameter int MAX_LEN  = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  chd_pkg::item_t    item,
  input  chd_pkg::cmd_t     cmd,
  output chd_pkg::sts_t     sts,
  output logic              res_valid,
  input  logic              res_ready,
  output chd_pkg::result_t  res_data
);

  localparam int AW  = $clog2(ALPHABET);
  localparam int LCW = $clog2(ALPHABET + 1);
  localparam int IW  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int LW  = chd_pkg::LEN_W;
  localparam int CW  = chd_pkg::CODE_W;
  localparam int SW  = chd_pkg::SYM_W;
  localparam logic [LCW-1:0] FULL  = LCW'(ALPHABET);
  localparam logic [LW-1:0]  MAX_L = LW'(MAX_LEN);

  // storage (in the per-length tables entry i holds length i+1)
  logic [SW-1:0]               symbol_store [ALPHABET];
  logic [chd_pkg::CNT_W-1:0]   counts       [MAX_LEN];
  logic [CW-1:0]               limit        [MAX_LEN];
  logic [SW-1:0]               rank_end     [MAX_LEN];

  logic [LCW-1:0] loaded_count;
  logic [LW-1:0]  seen_min, seen_max;
  logic [LW-1:0]  shortest, longest;
  logic [CW-1:0]  codeword;
  logic [LW-1:0]  bits_taken;
  logic           table_ready;

  logic [LW-1:0]  walk_len;
  logic [SW-1:0]  ranks;
  logic [CW-1:0]  prev_limit;
  logic [SW-1:0]  rank_r;
  chd_pkg::result_t res;

  logic                      load_bad, good_load, accept_build;
  logic                      early_bad;
  logic [LW-1:0]             cnt_len;
  logic [IW-1:0]             cnt_idx;
  logic [chd_pkg::CNT_W-1:0] cnt_rd;
  logic [SW-1:0]             ranks_next;
  logic [CW-1:0]             limit_next;
  logic [IW-1:0]             look_idx;
  logic [CW-1:0]             lim_rd;
  logic [SW-1:0]             rend_rd;
  logic                      in_range, match, overrun;
  logic [SW-1:0]             rank;

  assign load_bad  = (item.code_length == '0) || (item.code_length > MAX_L)
                     || (loaded_count >= FULL);
  assign good_load = cmd.accept && (item.opcode == chd_pkg::OP_LOAD) && !load_bad;
  assign accept_build = cmd.accept && (item.opcode == chd_pkg::OP_BUILD);
  assign early_bad = cmd.accept &&
                     (((item.opcode == chd_pkg::OP_LOAD) && load_bad) ||
                      ((item.opcode == chd_pkg::OP_BIT) && !table_ready));

  // single count read port: walk length during build, else load length
  assign cnt_len = cmd.walk ? walk_len : item.code_length;
  assign cnt_idx = IW'(cnt_len - LW'(1));
  assign cnt_rd  = counts[cnt_idx];

  assign ranks_next = ranks + cnt_rd[SW-1:0];
  always_comb begin
    if (walk_len == shortest) begin
      limit_next = CW'(cnt_rd) - CW'(1);
    end else begin
      limit_next = ((prev_limit + CW'(1)) << 1) + CW'(cnt_rd) - CW'(1);
    end
  end

  // decode compare
  assign look_idx = IW'(bits_taken - LW'(1));
  assign lim_rd   = limit[look_idx];
  assign rend_rd  = rank_end[look_idx];
  assign in_range = (bits_taken >= shortest) && (bits_taken <= MAX_L);
  assign match    = in_range && (codeword <= lim_rd);
  assign overrun  = !match && (bits_taken >= longest);
  assign rank     = rend_rd - (lim_rd[SW-1:0] - codeword[SW-1:0]);

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LEN; i++) counts[i] <= '0;
      loaded_count <= '0;
      seen_min     <= chd_pkg::LEN_NONE;
      seen_max     <= '0;
      shortest     <= chd_pkg::LEN_NONE;
      longest      <= '0;
      codeword     <= '0;
      bits_taken   <= '0;
      table_ready  <= 1'b0;
      res_valid    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        case (item.opcode)
          chd_pkg::OP_CLEAR: begin
            for (int i = 0; i < MAX_LEN; i++) counts[i] <= '0;
            loaded_count <= '0;
            seen_min     <= chd_pkg::LEN_NONE;
            seen_max     <= '0;
            shortest     <= chd_pkg::LEN_NONE;
            longest      <= '0;
            codeword     <= '0;
            bits_taken   <= '0;
            table_ready  <= 1'b0;
          end
          chd_pkg::OP_LOAD: begin
            if (!load_bad) begin
              counts[cnt_idx] <= cnt_rd + chd_pkg::CNT_W'(1);
              loaded_count    <= loaded_count + LCW'(1);
              if (item.code_length < seen_min) seen_min <= item.code_length;
              if (item.code_length > seen_max) seen_max <= item.code_length;
              table_ready     <= 1'b0;
            end
          end
          chd_pkg::OP_BUILD: begin
            shortest    <= seen_min;
            longest     <= seen_max;
            codeword    <= '0;
            bits_taken  <= '0;
            table_ready <= 1'b0;
          end
          chd_pkg::OP_BIT: begin
            if (table_ready) begin
              codeword   <= {codeword[CW-2:0], item.bit_value};
              bits_taken <= bits_taken + LW'(1);
            end
          end
          default: ;
        endcase
      end
      if (cmd.walk && (walk_len == longest)) table_ready <= 1'b1;
      if (cmd.look && (match || overrun)) begin
        codeword   <= '0;
        bits_taken <= '0;
      end
      if (cmd.push) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // payload and tables
  always_ff @(posedge clk) begin
    if (good_load) symbol_store[loaded_count[AW-1:0]] <= item.symbol_in;
    if (accept_build) begin
      walk_len <= seen_min;
      ranks    <= '0;
    end
    if (cmd.walk) begin
      rank_end[cnt_idx] <= ranks_next - SW'(1);
      limit[cnt_idx]    <= limit_next;
      prev_limit        <= limit_next;
      ranks             <= ranks_next;
      walk_len          <= walk_len + LW'(1);
    end
    if (cmd.look) rank_r <= rank;
    if (early_bad) begin
      res.symbol_out <= '0;
      res.status     <= chd_pkg::STATUS_BAD;
    end
    if (cmd.look && overrun) begin
      res.symbol_out <= '0;
      res.status     <= chd_pkg::STATUS_OVERRUN;
    end
    if (cmd.fetch) begin
      res.symbol_out <= symbol_store[rank_r[AW-1:0]];
      res.status     <= chd_pkg::STATUS_OK;
    end
    if (cmd.push) res_data <= res;
  end

  always_comb begin
    sts.opcode      = item.opcode;
    sts.load_bad    = load_bad;
    sts.has_symbols = (loaded_count != '0);
    sts.table_ready = table_ready;
    sts.walk_last   = (walk_len == longest);
    sts.match       = match;
    sts.overrun     = overrun;
    sts.out_free    = !res_valid || res_ready;
  end

endmodule

// ===== rtl/canonical_huffman_decoder.sv =====
// ----------------------------------------------------------------------------
// canonical_huffman_decoder: canonical Huffman table builder and bit decoder
// Loads symbols in rank order, builds per-length limits, decodes a bit stream.
// ----------------------------------------------------------------------------
// Items arrive on "items" and answers leave on "results", one transfer per
// handshake. A clear or a good load answers nothing. A build makes a single
// walk over the per-length counts, from the shortest to the longest loaded
// code length (at most MAX_LEN). A code bit goes through accept and limit
// compare while the codeword is still incomplete, adds a result push when
// it overruns the longest length, and goes through accept, limit compare,
// symbol store read and result push when it completes a symbol. A bad load,
// or a bit sent while no table is built, answers status 2. Results go
// through a one-entry output register; the next item is taken while a
// result waits there, and only a further result stalls behind it. There
// is no power-up clearing pass: the block takes items right after reset.
// Symbols, limits and rank ends hold garbage until loaded or built.
// ----------------------------------------------------------------------------
module canonical_huffman_decoder #(
  parameter int ALPHABET = 256,  // symbols that a table may hold, 2..256
  parameter int MAX_LEN  = 32    // longest code length, 1..32
) (
  input  logic       clk,
  input  logic       rst,
  chd_chan_if.sink   items,
  chd_chan_if.source results
);

  chd_pkg::cmd_t cmd;
  chd_pkg::sts_t sts;
  logic          in_ready;

  // Controller: walks each item through its steps.
  chd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: tables, codeword shift register, compare and output register.
  chd_datapath #(
    .ALPHABET (ALPHABET),
    .MAX_LEN  (MAX_LEN)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (items.data),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (results.valid),
    .res_ready (results.ready),
    .res_data  (results.data)
  );

  // Items transfer only while the controller is idle.
  assign items.ready = in_ready;

endmodule

// ===== rtl/chd_checker.sv =====
// ----------------------------------------------------------------------------
// chd_checker: port-level checks of the canonical Huffman decoder
// Watches the item and result channels over time.
// ----------------------------------------------------------------------------
module chd_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input chd_pkg::item_t   in_data,
  input logic             out_valid,
  input logic             out_ready,
  input chd_pkg::result_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

  // clear never answers
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.opcode == chd_pkg::OP_CLEAR) && !out_valid
    |=> !out_valid)
    else $error("clear produced a result");

  // build never answers
  a_build_quiet: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.opcode == chd_pkg::OP_BUILD) && !out_valid
    |=> !out_valid)
    else $error("build produced a result");

  // a code bit always goes on to a lookup or a result push
  a_bit_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_data.opcode == chd_pkg::OP_BIT) |=> !in_ready)
    else $error("ready right after a code bit");

endmodule

bind canonical_huffman_decoder chd_checker u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (items.valid),
  .in_ready  (items.ready),
  .in_data   (items.data),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_data  (results.data)
);
